// ----- hw/rtl/pwm3_pkg.sv -----
// Shared types, constants and a helper function for the three-channel PWM/PDM drive.
`timescale 1ns / 1ps

package pwm3_pkg;

	localparam int unsigned MODE_COUNT    = 4;
	localparam int unsigned MODE_W        = 2;
	localparam int unsigned WORD_W        = 22;
	localparam int unsigned DUTY_W        = 7;
	localparam int unsigned SLICE_W       = 7;
	localparam int unsigned SLICES_DEFAULT = 100;

	localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;

	localparam logic [WORD_W-1:0] MODE0_RESET = 22'd2103602;
	localparam logic [WORD_W-1:0] MODE1_RESET = 22'd10250;
	localparam logic [WORD_W-1:0] MODE2_RESET = 22'd1360;
	localparam logic [WORD_W-1:0] MODE3_RESET = 22'd2916352;

	localparam logic [MODE_W-1:0] MODE_STEP_DOWN = 2'd3;
	localparam logic [MODE_W-1:0] MODE_STEP_UP   = 2'd1;

	// Field view of one mode register.
	typedef struct packed {
		logic              pwm;
		logic [DUTY_W-1:0] yellow;
		logic [DUTY_W-1:0] green;
		logic [DUTY_W-1:0] red;
	} mode_word_t;

	typedef logic [WORD_W-1:0] word_t;

	// Clamp a raw 7-bit duty to the full-scale value.
	function automatic logic [DUTY_W-1:0] duty_sat(input logic [DUTY_W-1:0] d);
		duty_sat = (d > DUTY_FULL) ? DUTY_FULL : d;
	endfunction

endpackage

// ----- hw/rtl/pwm_pdm_three_channel_drive.sv -----
// Top level of the three-channel PWM / first-order PDM drive with two-button mode select.
`timescale 1ns / 1ps

// Each request on the input stream is one time slice and produces exactly one result:
// the drive levels of the red, green and yellow channels and the mode that set them.
// The block takes one request per clock cycle while the downstream side keeps up; a request
// is captured in an input stage, and from there the button edge detection, mode latch, duty
// clamp and the PWM compare or PDM accumulate all run in one pass of short logic into the
// output register. A new request is taken whenever the input stage is empty or moving
// on, so one can be taken while a finished result still waits for the downstream side.
// Buttons are active low and are looked at only in slices that carry the sample strobe;
// a falling edge of button A steps the selected mode down, of button B up, both wrapping
// over four modes. The selected mode takes effect only when the slice counter is zero,
// so a PWM period of SLICES slices always completes. The user must write the four mode
// registers through the plain write port only while the block is idle; the block itself
// does not enforce it. Each register holds the three 7-bit duties (values above 100 drive
// as 100) and a flag that picks PWM (set) or PDM (clear).
module pwm_pdm_three_channel_drive #(
	parameter int unsigned SLICES = pwm3_pkg::SLICES_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// [0] button_a, [1] button_b, [2] sample_now, [7:3] zero
	input  logic [7:0]                  s_axis_tdata,

	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// [0] red_on, [1] green_on, [2] yellow_on, [4:3] active_mode_out, [7:5] zero
	output logic [7:0]                  m_axis_tdata,

	input  logic                        cfg_we,
	input  logic [pwm3_pkg::MODE_W-1:0] cfg_index,
	input  logic [pwm3_pkg::WORD_W-1:0] cfg_data
);
	import pwm3_pkg::*;

	// Mode registers.
	word_t mode_q [MODE_COUNT];

	// Input stage.
	logic       valid_s1;
	logic       btn_a_s1, btn_b_s1, sample_s1;

	// Drive state.
	logic [MODE_W-1:0]  sel_mode_q, act_mode_q;
	logic               last_a_q, last_b_q;
	logic [SLICE_W-1:0] slice_q;
	logic [DUTY_W-1:0]  red_acc_q, green_acc_q, yellow_acc_q;

	// Output register.
	logic               out_valid_q;
	logic [4:0]         out_data_q;

	// The input stage moves into the output register whenever that register is free
	// or being emptied in the same cycle.
	logic advance;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Next-state and result logic for the slice held in the input stage.
	logic [MODE_W-1:0]  sel_next, act_next;
	logic               last_a_next, last_b_next;
	mode_word_t         word;
	logic [DUTY_W-1:0]  r_duty, g_duty, y_duty;
	logic [SLICE_W:0]   slice_inc;
	logic [SLICE_W-1:0] slice_next;
	logic [DUTY_W:0]    r_sum, g_sum, y_sum;
	logic               r_hit, g_hit, y_hit;
	logic [DUTY_W-1:0]  r_acc_next, g_acc_next, y_acc_next;
	logic               r_on, g_on, y_on;

	always_comb begin
		sel_next    = sel_mode_q;
		last_a_next = last_a_q;
		last_b_next = last_b_q;
		if (sample_s1) begin
			if (last_a_q && !btn_a_s1) begin
				sel_next = sel_next + MODE_STEP_DOWN;
			end
			if (last_b_q && !btn_b_s1) begin
				sel_next = sel_next + MODE_STEP_UP;
			end
			last_a_next = btn_a_s1;
			last_b_next = btn_b_s1;
		end

		// A new mode only takes over at the start of a period.
		act_next = (slice_q == '0) ? sel_next : act_mode_q;

		word   = mode_word_t'(mode_q[act_next]);
		r_duty = duty_sat(word.red);
		g_duty = duty_sat(word.green);
		y_duty = duty_sat(word.yellow);

		slice_inc = {1'b0, slice_q} + {{SLICE_W{1'b0}}, 1'b1};

		r_sum = {1'b0, red_acc_q}    + {1'b0, r_duty};
		g_sum = {1'b0, green_acc_q}  + {1'b0, g_duty};
		y_sum = {1'b0, yellow_acc_q} + {1'b0, y_duty};
		r_hit = r_sum >= {1'b0, DUTY_FULL};
		g_hit = g_sum >= {1'b0, DUTY_FULL};
		y_hit = y_sum >= {1'b0, DUTY_FULL};

		r_acc_next = red_acc_q;
		g_acc_next = green_acc_q;
		y_acc_next = yellow_acc_q;

		if (word.pwm) begin
			r_on = slice_q < r_duty;
			g_on = slice_q < g_duty;
			y_on = slice_q < y_duty;
			slice_next = (slice_inc >= (SLICE_W+1)'(SLICES)) ? '0 : slice_inc[SLICE_W-1:0];
		end else begin
			r_on = r_hit;
			g_on = g_hit;
			y_on = y_hit;
			r_acc_next = r_hit ? DUTY_W'(r_sum - {1'b0, DUTY_FULL}) : r_sum[DUTY_W-1:0];
			g_acc_next = g_hit ? DUTY_W'(g_sum - {1'b0, DUTY_FULL}) : g_sum[DUTY_W-1:0];
			y_acc_next = y_hit ? DUTY_W'(y_sum - {1'b0, DUTY_FULL}) : y_sum[DUTY_W-1:0];
			slice_next = '0;
		end
	end

	// Mode register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q[0] <= MODE0_RESET;
			mode_q[1] <= MODE1_RESET;
			mode_q[2] <= MODE2_RESET;
			mode_q[3] <= MODE3_RESET;
		end else if (cfg_we) begin
			mode_q[cfg_index] <= cfg_data;
		end
	end

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			btn_a_s1  <= s_axis_tdata[0];
			btn_b_s1  <= s_axis_tdata[1];
			sample_s1 <= s_axis_tdata[2];
		end
	end

	// Drive state advances once per slice.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_mode_q   <= '0;
			act_mode_q   <= '0;
			last_a_q     <= 1'b1;
			last_b_q     <= 1'b1;
			slice_q      <= '0;
			red_acc_q    <= '0;
			green_acc_q  <= '0;
			yellow_acc_q <= '0;
		end else if (advance) begin
			sel_mode_q   <= sel_next;
			act_mode_q   <= act_next;
			last_a_q     <= last_a_next;
			last_b_q     <= last_b_next;
			slice_q      <= slice_next;
			red_acc_q    <= r_acc_next;
			green_acc_q  <= g_acc_next;
			yellow_acc_q <= y_acc_next;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {act_next, y_on, g_on, r_on};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_data_q};

	// The slice counter always stays inside one PWM period.
	assert property (@(posedge clk) disable iff (!arst_n)
		slice_q < (SLICE_W)'(SLICES))
		else $error("slice counter left the PWM period");

	// PDM accumulators stay below full scale.
	assert property (@(posedge clk) disable iff (!arst_n)
		(red_acc_q < DUTY_FULL) && (green_acc_q < DUTY_FULL) && (yellow_acc_q < DUTY_FULL))
		else $error("PDM accumulator reached full scale");

	// The active mode only changes at the start of a period.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && (slice_q == '0)) |=> $stable(act_mode_q))
		else $error("active mode changed mid-period");

	// A slice held in the input stage is never dropped.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input stage lost a slice");

endmodule
